// ===== rtl/xor_checked_frame_receiver_macros.svh =====
// Assertion helpers for the frame receiver. Both forms sample on clk and
// are disabled while arst_n is low.
`ifndef XOR_CHECKED_FRAME_RECEIVER_MACROS_SVH
`define XOR_CHECKED_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTH
`define XCFR_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define XCFR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define XCFR_ASSERT_SAME(lbl, ante, cons)
`define XCFR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/xcfr_pkg.sv =====
package xcfr_pkg;

	localparam int PAYLOAD_BYTES_DEF = 8;
	localparam int PAYLOAD_W         = 64;
	localparam int IDLE_W            = 17;
	localparam int TIMEOUT_W         = 16;
	localparam int MARKER_W          = 8;
	localparam int CFG_DATA_W        = 16;

	localparam logic [MARKER_W-1:0]  START_MARKER_RST = 8'hAA;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST      = 16'd250;

	typedef enum logic [1:0] {
		PH_WAIT,
		PH_DATA,
		PH_SUM
	} phase_t;

	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_TICK = 1'b1
	} kind_t;

	typedef enum logic {
		EV_FRAME   = 1'b0,
		EV_TIMEOUT = 1'b1
	} event_t;

	typedef enum logic {
		REG_START_MARKER  = 1'b0,
		REG_TIMEOUT_TICKS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic                 event_res;
		logic [PAYLOAD_W-1:0] payload;
		logic                 link_up;
	} res_t;

endpackage

// ===== rtl/xcfr_core.sv =====
`include "xor_checked_frame_receiver_macros.svh"

module xcfr_core #(
	parameter int PAYLOAD_BYTES = xcfr_pkg::PAYLOAD_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             kind,
	input  logic [7:0]                       rx_byte,
	input  logic                             cfg_valid,
	input  logic                             cfg_index,
	input  logic [xcfr_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                             res_valid,
	output xcfr_pkg::res_t                   res
);

	localparam int CNT_W   = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
	localparam int STORE_W = 8 * PAYLOAD_BYTES;
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PAYLOAD_BYTES - 1);

	xcfr_pkg::phase_t                  phase_q, phase_d;
	logic [CNT_W-1:0]                  cnt_q;
	logic [7:0]                        xor_q;
	logic [STORE_W-1:0]                store_q;
	logic [xcfr_pkg::IDLE_W-1:0]       idle_q, idle_inc;
	logic                              connected_q;
	logic                              timed_out_q;
	logic [xcfr_pkg::MARKER_W-1:0]     marker_q;
	logic [xcfr_pkg::TIMEOUT_W-1:0]    timeout_q;

	logic is_tick;
	logic start;
	logic take;
	logic fire;
	logic sum_ok;

	assign is_tick  = (kind == xcfr_pkg::KIND_TICK);
	assign idle_inc = (idle_q == '1) ? idle_q : idle_q + 1'b1;
	assign fire     = is_tick && !timed_out_q && (idle_inc > {1'b0, timeout_q});

	always_comb begin
		phase_d = phase_q;
		if (!is_tick) begin
			unique case (phase_q)
				xcfr_pkg::PH_DATA: begin
					if (cnt_q == LAST_CNT)
						phase_d = xcfr_pkg::PH_SUM;
				end
				xcfr_pkg::PH_SUM: begin
					phase_d = xcfr_pkg::PH_WAIT;
				end
				default: begin
					phase_d = (rx_byte == marker_q) ? xcfr_pkg::PH_DATA : xcfr_pkg::PH_WAIT;
				end
			endcase
		end
	end

	always_comb begin
		start  = 1'b0;
		take   = 1'b0;
		sum_ok = 1'b0;
		if (!is_tick) begin
			unique case (phase_q)
				xcfr_pkg::PH_DATA: begin
					take = 1'b1;
				end
				xcfr_pkg::PH_SUM: begin
					sum_ok = (rx_byte == xor_q);
				end
				default: begin
					start = (rx_byte == marker_q);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= xcfr_pkg::PH_WAIT;
			cnt_q       <= '0;
			xor_q       <= '0;
			idle_q      <= '0;
			connected_q <= 1'b0;
			timed_out_q <= 1'b0;
		end else if (in_valid) begin
			phase_q <= phase_d;
			if (start) begin
				cnt_q <= '0;
				xor_q <= '0;
			end
			if (take) begin
				cnt_q <= (cnt_q == LAST_CNT) ? '0 : cnt_q + 1'b1;
				xor_q <= xor_q ^ rx_byte;
			end
			if (is_tick)
				idle_q <= idle_inc;
			if (fire) begin
				timed_out_q <= 1'b1;
				connected_q <= 1'b0;
			end
			if (sum_ok) begin
				idle_q      <= '0;
				timed_out_q <= 1'b0;
				connected_q <= 1'b1;
			end
		end
	end

	// every lane is rewritten before the checksum byte, so no clear needed
	always_ff @(posedge clk) begin
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			if (in_valid && take && cnt_q == CNT_W'(i))
				store_q[i*8 +: 8] <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q  <= xcfr_pkg::START_MARKER_RST;
			timeout_q <= xcfr_pkg::TIMEOUT_RST;
		end else if (cfg_valid) begin
			unique case (xcfr_pkg::reg_idx_t'(cfg_index))
				xcfr_pkg::REG_START_MARKER:  marker_q  <= cfg_data[xcfr_pkg::MARKER_W-1:0];
				xcfr_pkg::REG_TIMEOUT_TICKS: timeout_q <= cfg_data[xcfr_pkg::TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		res_valid     = in_valid && (fire || sum_ok);
		res.event_res = fire ? xcfr_pkg::EV_TIMEOUT : xcfr_pkg::EV_FRAME;
		res.payload   = sum_ok ? xcfr_pkg::PAYLOAD_W'(store_q) : '0;
		res.link_up   = sum_ok ? 1'b1 : (fire ? 1'b0 : connected_q);
	end

	`XCFR_ASSERT_SAME(a_timeout_drops_link, timed_out_q, !connected_q)
	`XCFR_ASSERT_NEXT(a_frame_clears_idle, in_valid && sum_ok,
		idle_q == '0 && phase_q == xcfr_pkg::PH_WAIT)
	`XCFR_ASSERT_SAME(a_sum_count_wrapped, phase_q == xcfr_pkg::PH_SUM, cnt_q == '0)

endmodule

// ===== rtl/xcfr_obuf.sv =====
`include "xor_checked_frame_receiver_macros.svh"

module xcfr_obuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  xcfr_pkg::res_t push_res,
	output logic           ready,
	output logic           m_valid,
	input  logic           m_ready,
	output xcfr_pkg::res_t m_res
);

	logic           main_valid_q;
	logic           skid_valid_q;
	xcfr_pkg::res_t main_q;
	xcfr_pkg::res_t skid_q;

	assign ready   = !skid_valid_q;
	assign m_valid = main_valid_q;
	assign m_res   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_ready)
				skid_valid_q <= 1'b0;
		end else if (push) begin
			if (main_valid_q && !m_ready)
				skid_valid_q <= 1'b1;
			else
				main_valid_q <= 1'b1;
		end else if (m_ready) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_ready)
				main_q <= skid_q;
		end else if (push) begin
			if (main_valid_q && !m_ready)
				skid_q <= push_res;
			else
				main_q <= push_res;
		end
	end

	`XCFR_ASSERT_SAME(a_skid_behind_main, skid_valid_q, main_valid_q)
	`XCFR_ASSERT_NEXT(a_stall_fills_skid, push && main_valid_q && !m_ready, skid_valid_q)
	`XCFR_ASSERT_NEXT(a_skid_holds, skid_valid_q && !m_ready, $stable(skid_q))

endmodule

// ===== rtl/xor_checked_frame_receiver.sv =====
// Framed serial receiver with XOR checksum and link watchdog.
// Input words (s_*): s_tuser is the kind (0 serial byte, 1 millisecond
// tick), s_tdata the received byte. A frame is the start marker, then
// PAYLOAD_BYTES payload bytes, then the XOR of the payload bytes.
// Output words (m_*): m_tuser 0 carries a good frame with its payload and
// link_up set; 1 is a single watchdog timeout with zero payload, link_up
// clear. Bad checksums and stray bytes produce no word.
// Config channel: cfg_index 0 start marker, 1 timeout in ticks; always ready.
// Throughput: one input word per cycle while s_tready is high. A result
// is registered into the main or skid output register when its input word is taken.
// Output is a main register plus a one-word skid register; a stalled m_tready
// fills the skid, and s_tready drops only while the skid is occupied.
// Reset (arst_n low) clears the frame state, idle counter and link flag, and
// loads start marker 0xAA and timeout 250.
module xor_checked_frame_receiver #(
	parameter int PAYLOAD_BYTES = xcfr_pkg::PAYLOAD_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] rx_byte
	input  logic                            s_tuser,   // [0] kind
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [71:0]                     m_tdata,   // [63:0] payload, [64] link_up
	output logic                            m_tuser,   // [0] event_res
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [xcfr_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic           in_accept;
	logic           res_valid;
	xcfr_pkg::res_t res;
	xcfr_pkg::res_t out_res;

	assign cfg_ready = 1'b1;
	assign in_accept = s_tvalid && s_tready;

	xcfr_core #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_accept),
		.kind      (s_tuser),
		.rx_byte   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_valid (res_valid),
		.res       (res)
	);

	xcfr_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_res (res),
		.ready    (s_tready),
		.m_valid  (m_tvalid),
		.m_ready  (m_tready),
		.m_res    (out_res)
	);

	assign m_tdata = {7'b0, out_res.link_up, out_res.payload};
	assign m_tuser = out_res.event_res;

endmodule
